[hdl/psa_pkg.sv]
// shared types and constants for the per-user session aggregator
package psa_pkg;

  localparam int unsigned USER_SLOTS   = 4096;
  localparam int unsigned ACTION_KINDS = 8;

  localparam int unsigned USER_AW = $clog2(USER_SLOTS);
  localparam int unsigned ACT_AW  = (ACTION_KINDS > 1) ? $clog2(ACTION_KINDS) : 1;
  localparam int unsigned CTR_AW  = USER_AW + ACT_AW;
  localparam int unsigned CTR_DEPTH = USER_SLOTS << ACT_AW;

  localparam logic [31:0] CTR_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_EMIT,
    S_FINISH
  } state_e;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  typedef logic [ACTION_KINDS-1:0] mask_t;

  typedef struct packed {
    logic        op;
    logic [11:0] user;
    logic [31:0] session;
    logic [47:0] stamp;
    logic [2:0]  action;
  } req_t;

  typedef struct packed {
    logic [11:0] user_out;
    logic [31:0] session_out;
    logic [47:0] start_time;
    logic [47:0] end_time;
    logic [2:0]  action_index;
    logic [31:0] action_count;
    logic        last;
  } res_t;

  // one session table entry; mask marks counters written since the session opened
  typedef struct packed {
    logic        valid;
    logic [31:0] session;
    logic [47:0] first_time;
    logic [47:0] latest_time;
    mask_t       mask;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[hdl/psa_ram.sv]
// generic simple dual-port ram with registered read
module psa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/per_user_session_aggregator_unit.sv]
// top level: per-user session table with sequenced record emission
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+----------------------
//   request | in        | start_i high, busy_o low | req_i  (psa_pkg::req_t)
//   result  | out       | res_strobe_o, one cycle  | res_o  (psa_pkg::res_t)
//
// an access that stays in its session, opens one, or a flush of a closed slot goes
// from eval straight back to idle; one that emits a record also passes through emit
// and finish, paced by the single read port of the counter ram, one counter per cycle.
// after reset the session table is swept clear, slot by slot, with busy high.
// results are registered in res_q after their counter leaves the ram; the receiver cannot stall.
module per_user_session_aggregator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  psa_pkg::req_t req_i,
  output logic          res_strobe_o,
  output psa_pkg::res_t res_o
);
  import psa_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  entry_t ent_q;
  logic [USER_AW-1:0] clr_q, clr_d;
  logic [ACT_AW-1:0]  k_q, k_d;
  res_t res_q, res_d;
  logic res_strobe_q, res_strobe_d;

  // ram ports
  logic               ent_we, ent_re;
  logic [USER_AW-1:0] ent_waddr, ent_raddr;
  entry_t             ent_wdata, ent_rdata;
  logic [ENTRY_W-1:0] ent_rbits;
  logic               ctr_we, ctr_re;
  logic [CTR_AW-1:0]  ctr_waddr, ctr_raddr;
  logic [31:0]        ctr_wdata, ctr_rdata;

  logic               accept;
  logic               user_ok, act_ok, same_sess, later;
  logic [USER_AW-1:0] uidx;
  logic [ACT_AW-1:0]  aidx;
  mask_t              act_bit;
  logic [31:0]        ctr_old, ctr_inc;
  entry_t             ent_open;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign ent_rdata = entry_t'(ent_rbits);

  assign uidx    = USER_AW'(req_q.user);
  assign aidx    = ACT_AW'(req_q.action);
  assign user_ok = 32'(req_q.user) < 32'(USER_SLOTS);
  assign act_ok  = 32'(req_q.action) < 32'(ACTION_KINDS);
  assign act_bit = act_ok ? (mask_t'(1) << req_q.action) : '0;

  // shared compare and increment unit
  assign same_sess = (ent_rdata.session == req_q.session);
  assign later     = (req_q.stamp > ent_rdata.latest_time);
  assign ctr_old   = ent_rdata.mask[aidx] ? ctr_rdata : 32'd0;
  assign ctr_inc   = (ctr_old == CTR_MAX) ? ctr_old : ctr_old + 32'd1;

  // fresh entry for a newly opened session
  always_comb begin
    ent_open             = '0;
    ent_open.valid       = 1'b1;
    ent_open.session     = req_q.session;
    ent_open.first_time  = req_q.stamp;
    ent_open.latest_time = req_q.stamp;
    ent_open.mask        = act_bit;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == USER_AW'(USER_SLOTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (user_ok && ent_rdata.valid &&
            (req_q.op == OP_FLUSH || !same_sess)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (k_q == ACT_AW'(ACTION_KINDS - 1)) state_d = S_FINISH;
      end
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ent_we       = 1'b0;
    ent_waddr    = uidx;
    ent_wdata    = ent_open;
    ent_re       = 1'b0;
    ent_raddr    = USER_AW'(req_i.user);
    ctr_we       = 1'b0;
    ctr_waddr    = {uidx, aidx};
    ctr_wdata    = 32'd1;
    ctr_re       = 1'b0;
    ctr_raddr    = {USER_AW'(req_i.user), ACT_AW'(req_i.action)};
    clr_d        = clr_q;
    k_d          = k_q;
    res_d        = res_q;
    res_strobe_d = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
        clr_d     = clr_q + USER_AW'(1);
      end
      S_IDLE: begin
        ent_re = accept;
        ctr_re = accept;
      end
      S_EVAL: begin
        k_d = '0;
        if (user_ok) begin
          if (ent_rdata.valid && (req_q.op == OP_FLUSH || !same_sess)) begin
            ctr_re    = 1'b1;
            ctr_raddr = {uidx, ACT_AW'(0)};
          end else if (req_q.op == OP_ACCESS && !ent_rdata.valid) begin
            ent_we = 1'b1;
            ctr_we = act_ok;
          end else if (req_q.op == OP_ACCESS) begin
            ent_we                = 1'b1;
            ent_wdata             = ent_rdata;
            ent_wdata.mask        = ent_rdata.mask | act_bit;
            ent_wdata.latest_time = later ? req_q.stamp : ent_rdata.latest_time;
            ctr_we                = act_ok;
            ctr_wdata             = ctr_inc;
          end
        end
      end
      S_EMIT: begin
        res_strobe_d       = 1'b1;
        res_d.user_out     = req_q.user;
        res_d.session_out  = ent_q.session;
        res_d.start_time   = ent_q.first_time;
        res_d.end_time     = ent_q.latest_time;
        res_d.action_index = 3'(k_q);
        res_d.action_count = ent_q.mask[k_q] ? ctr_rdata : 32'd0;
        res_d.last         = (k_q == ACT_AW'(ACTION_KINDS - 1));
        if (k_q != ACT_AW'(ACTION_KINDS - 1)) begin
          k_d       = k_q + ACT_AW'(1);
          ctr_re    = 1'b1;
          ctr_raddr = {uidx, k_d};
        end
      end
      S_FINISH: begin
        ent_we = 1'b1;
        if (req_q.op == OP_FLUSH) begin
          ent_wdata       = ent_q;
          ent_wdata.valid = 1'b0;
        end else begin
          ctr_we = act_ok;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      k_q          <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      k_q          <= k_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_EVAL) begin
      ent_q <= ent_rdata;
    end
    res_q <= res_d;
  end

  psa_ram #(
    .Width(ENTRY_W),
    .Depth(USER_SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .re_i   (ent_re),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rbits)
  );

  psa_ram #(
    .Width(32),
    .Depth(CTR_DEPTH)
  ) u_ctr_ram (
    .clk_i  (clk_i),
    .we_i   (ctr_we),
    .waddr_i(ctr_waddr),
    .wdata_i(ctr_wdata),
    .re_i   (ctr_re),
    .raddr_i(ctr_raddr),
    .rdata_o(ctr_rdata)
  );

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

[hdl/psa_chk.sv]
// port-level checks for the session aggregator, bound to the top level
module psa_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          res_strobe_o,
  input psa_pkg::res_t res_o
);

  // results of a record only show while the block is busy
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> busy_o)
    else $error("result word outside busy window");

  // an accepted word makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accept");

  // the words of one record come back to back
  a_record_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.last) |=> res_strobe_o)
    else $error("gap inside emitted record");

  // the action index steps up by one within a record, same user
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && $past(res_strobe_o) && !$past(res_o.last)) |->
      (res_o.action_index == 3'($past(res_o.action_index) + 3'd1) &&
       res_o.user_out == $past(res_o.user_out)))
    else $error("action index or user broke within record");

  // a record ends with a quiet cycle
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |=> !res_strobe_o)
    else $error("word right after last word");

endmodule

bind per_user_session_aggregator_unit psa_chk u_psa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_strobe_o(res_strobe_o),
  .res_o       (res_o)
);

[tb/tb.sv]
// testbench for the per-user session aggregator: directed and random words against a local session table
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psa_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic res_strobe_o;
  res_t res_o;

  per_user_session_aggregator_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_i        (req_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // local copy of the session table
  bit        open_live [USER_SLOTS];
  bit [31:0] open_sess [USER_SLOTS];
  bit [47:0] t_first   [USER_SLOTS];
  bit [47:0] t_latest  [USER_SLOTS];
  bit [31:0] act_cnt   [USER_SLOTS][ACTION_KINDS];

  res_t      closed_rows[$];
  int        fail_count = 0;
  int        burst_left = 0;
  bit [47:0] clock_us   = 48'd1000;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic note_mismatch(input string what);
    $display("tb: mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic req_t mk(input op_e op, input logic [11:0] user, input logic [31:0] sess,
                              input logic [47:0] stamp, input logic [2:0] act);
    req_t r;
    r.op      = op;
    r.user    = user;
    r.session = sess;
    r.stamp   = stamp;
    r.action  = act;
    return r;
  endfunction

  // one row per action counter of the record being closed
  function automatic void queue_record(input int unsigned u);
    res_t row;
    for (int k = 0; k < ACTION_KINDS; k++) begin
      row.user_out     = u[11:0];
      row.session_out  = open_sess[u];
      row.start_time   = t_first[u];
      row.end_time     = t_latest[u];
      row.action_index = k[2:0];
      row.action_count = act_cnt[u][k];
      row.last         = (k == ACTION_KINDS - 1);
      closed_rows      = {closed_rows, row};
    end
  endfunction

  function automatic void open_session(input int unsigned u, input bit [31:0] sess,
                                       input bit [47:0] stamp);
    open_live[u] = 1'b1;
    open_sess[u] = sess;
    t_first[u]   = stamp;
    t_latest[u]  = stamp;
    for (int k = 0; k < ACTION_KINDS; k++) act_cnt[u][k] = '0;
  endfunction

  function automatic void track_session(input req_t r);
    int unsigned u;
    int unsigned a;
    u = 32'(r.user);
    a = 32'(r.action);
    if (u >= USER_SLOTS) return;
    if (r.op == OP_FLUSH) begin
      if (open_live[u]) begin
        queue_record(u);
        open_live[u] = 1'b0;
      end
      return;
    end
    if (!open_live[u]) begin
      open_session(u, r.session, r.stamp);
    end else if (open_sess[u] == r.session) begin
      if (r.stamp > t_latest[u]) t_latest[u] = r.stamp;
    end else begin
      queue_record(u);
      open_session(u, r.session, r.stamp);
    end
    if (a < ACTION_KINDS && act_cnt[u][a] != CTR_MAX) act_cnt[u][a]++;
  endfunction

  // called and returns at a falling edge; start stays high within a burst
  task automatic send_word(input req_t r);
    int gap;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    track_session(r);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_rows
    res_t want;
    if (rst_ni && res_strobe_o === 1'b1) begin
      if (closed_rows.size() == 0) begin
        note_mismatch("result with nothing expected");
      end else begin
        want = closed_rows.pop_front();
        cmp_field("user_out", 64'(res_o.user_out), 64'(want.user_out));
        cmp_field("session_out", 64'(res_o.session_out), 64'(want.session_out));
        cmp_field("start_time", 64'(res_o.start_time), 64'(want.start_time));
        cmp_field("end_time", 64'(res_o.end_time), 64'(want.end_time));
        cmp_field("action_index", 64'(res_o.action_index), 64'(want.action_index));
        cmp_field("action_count", 64'(res_o.action_count), 64'(want.action_count));
        cmp_field("last", 64'(res_o.last), 64'(want.last));
      end
    end
  end

  // open, extend, earlier and equal stamps, counting within each session
  task automatic test_open_extend();
    send_word(mk(OP_ACCESS, 12'd0, 32'd0, 48'd0, 3'd0));
    send_word(mk(OP_ACCESS, 12'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 3'd7));
    send_word(mk(OP_ACCESS, 12'd0, 32'd0, 48'd5, 3'd3));
    send_word(mk(OP_ACCESS, 12'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 3'd3));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5678, 48'd100, 3'd2));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5678, 48'd200, 3'd2));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5678, 48'd300, 3'd2));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5678, 48'd250, 3'd6));
  endtask

  // a new session on an open slot closes the old record first
  task automatic test_session_switch();
    send_word(mk(OP_ACCESS, 12'd4095, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7));
    send_word(mk(OP_ACCESS, 12'd4095, 32'd0, 48'd1, 3'd0));
    send_word(mk(OP_ACCESS, 12'd4095, 32'hAAAA_5555, 48'd2, 3'd4));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5679, 48'd400, 3'd1));
  endtask

  task automatic test_flush();
    send_word(mk(OP_FLUSH, 12'd0, 32'd0, 48'd0, 3'd0));
    send_word(mk(OP_FLUSH, 12'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd7));
    send_word(mk(OP_FLUSH, 12'd1, 32'd0, 48'd0, 3'd0));
    send_word(mk(OP_FLUSH, 12'd4095, 32'd0, 48'd0, 3'd0));
    send_word(mk(OP_FLUSH, 12'd5, 32'd0, 48'd0, 3'd0));
    send_word(mk(OP_ACCESS, 12'd5, 32'h1234_5679, 48'd500, 3'd5));
  endtask

  // mostly sessions of a few busy users, some stray users and flushes
  task automatic test_random(input int n);
    int unsigned pool[6];
    int unsigned u;
    int          roll;
    op_e         op;
    bit [31:0]   sess;
    bit [47:0]   stamp;
    foreach (pool[j]) pool[j] = $urandom_range(0, USER_SLOTS - 1);
    for (int i = 0; i < n; i++) begin
      u = ($urandom_range(0, 99) < 8) ? $urandom_range(0, USER_SLOTS - 1)
                                       : pool[$urandom_range(0, 5)];
      roll = $urandom_range(0, 99);
      op = (roll < 12) ? OP_FLUSH : OP_ACCESS;
      sess = (open_live[u] && roll < 75) ? open_sess[u] : $urandom;
      clock_us += 48'($urandom_range(0, 500));
      roll = $urandom_range(0, 19);
      if (roll == 0)
        stamp = 48'({$urandom, $urandom});
      else if (roll < 3)
        stamp = clock_us - 48'($urandom_range(0, 2000));
      else
        stamp = clock_us;
      send_word(mk(op, u[11:0], sess, stamp, 3'($urandom_range(0, 7))));
    end
  endtask

  // host-style drain: flush open slots and the last slot, walking user ids upward
  task automatic test_drain();
    for (int u = 0; u < USER_SLOTS; u++)
      if (open_live[u] || u == USER_SLOTS - 1)
        send_word(mk(OP_FLUSH, u[11:0], $urandom, 48'({$urandom, $urandom}),
                     3'($urandom_range(0, 7))));
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_open_extend();
    test_session_switch();
    test_flush();
    test_random(75);
    test_drain();

    start_i <= 1'b0;
    while (closed_rows.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule

[files.f]
hdl/psa_pkg.sv
hdl/psa_ram.sv
hdl/per_user_session_aggregator_unit.sv
hdl/psa_chk.sv
tb/tb.sv
